@@ sv/atp_pkg.sv @@
package atp_pkg;

    // Field and register widths.
    localparam int COORD_W       = 32;
    localparam int PAIR_W        = 64;
    localparam int NUM_PAIRS     = 8;
    localparam int PAIR_IDX_W    = 3;
    localparam int CFG_IDX_W     = 4;
    localparam int NUM_AXES      = 3;
    localparam int NUM_ROWS      = 4;
    localparam int NUM_COLS      = 4;
    localparam int FRAC_BITS_DEF = 16;

    // Internal arithmetic widths.
    localparam int PROD_W    = 2 * COORD_W;
    localparam int SUM_W     = PROD_W + 2;
    localparam int QUO_W     = COORD_W + 1;
    localparam int DIV_STEPS = QUO_W;

    typedef logic signed [COORD_W-1:0] t_coord;

    localparam t_coord SAT_POS = t_coord'(32'h7FFF_FFFF);
    localparam t_coord SAT_NEG = t_coord'(32'h8000_0000);
    localparam logic [QUO_W-1:0] LIM_POS = QUO_W'(32'h7FFF_FFFF);
    localparam logic [QUO_W-1:0] LIM_NEG = QUO_W'(32'h8000_0000);

    // Control that travels with each corner through the pipeline.
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
        logic box;
    } t_ctl;

    // One divider lane: partial remainder, and a shift register that holds the
    // dividend bits still to come in its top and the quotient bits in its bottom.
    typedef struct packed {
        logic [SUM_W-1:0] rem;
        logic [QUO_W-1:0] lq;
        logic             neg;
        logic             dz;
        logic             nz;
        logic             nneg;
        logic             ovf;
    } t_lane;

    // One restoring division step.
    function automatic t_lane div_step(input t_lane l, input logic [SUM_W-1:0] d);
        logic [SUM_W:0] trial;
        logic           qbit;
        t_lane          o;
        o     = l;
        trial = {l.rem, l.lq[QUO_W-1]};
        qbit  = (trial >= {1'b0, d});
        o.rem = qbit ? SUM_W'(trial - {1'b0, d}) : trial[SUM_W-1:0];
        o.lq  = {l.lq[QUO_W-2:0], qbit};
        return o;
    endfunction

endpackage

@@ sv/aabb_transform_project_unit.sv @@
// Projective transform of an axis-aligned box by a 4x4 fixed-point matrix.
//
// Input channel (i_in_valid / o_in_ready): one beat is one box. A valid box is
// expanded into its eight corners, one corner per cycle while the output is not
// stalled; a new box may be taken with the last corner, and an invalid box is
// one token and yields a zeroed, invalid result. Corners run through a 40-stage
// pipeline: 32x32 multiplies, a two-level row sum, a magnitude stage, and a
// 33-step restoring divider with one step per stage for the divide by w. A
// min/max accumulator closes the box. Output channel (o_out_valid /
// i_out_ready): one beat per input beat, in order.
// Configuration channel (i_cfg_valid / o_cfg_ready, always ready): index 0..7
// writes one 64-bit matrix pair; other indexes are ignored. Write only while
// the block holds no box in flight.
// Reset clears the matrix to zero and empties the pipeline. When the receiver
// stalls, the output register holds and the whole pipeline freezes in place;
// no corner is lost or repeated.
module aabb_transform_project_unit #(
    parameter int FRAC_BITS = atp_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [atp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [atp_pkg::PAIR_W-1:0]    i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_box_valid_in,
    input  atp_pkg::t_coord               i_in_min_x,
    input  atp_pkg::t_coord               i_in_min_y,
    input  atp_pkg::t_coord               i_in_min_z,
    input  atp_pkg::t_coord               i_in_max_x,
    input  atp_pkg::t_coord               i_in_max_y,
    input  atp_pkg::t_coord               i_in_max_z,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_box_valid_out,
    output atp_pkg::t_coord               o_out_min_x,
    output atp_pkg::t_coord               o_out_min_y,
    output atp_pkg::t_coord               o_out_min_z,
    output atp_pkg::t_coord               o_out_max_x,
    output atp_pkg::t_coord               o_out_max_y,
    output atp_pkg::t_coord               o_out_max_z,
    output logic                          o_degenerate_flag
);
    import atp_pkg::*;

    localparam int STG_MUL  = 1;
    localparam int STG_ADD  = 2;
    localparam int STG_ROW  = 3;
    localparam int STG_ABS  = 4;
    localparam int STG_DIV0 = 5;
    localparam int STG_FIN  = STG_DIV0 + DIV_STEPS + 1;
    localparam logic [2:0] LAST_CORNER = 3'd7;

    logic                adv;
    logic                in_acc;
    logic [PAIR_W-1:0]   r_pair [NUM_PAIRS];
    t_coord              m [NUM_ROWS][NUM_COLS];

    logic                r_busy;
    logic [2:0]          r_k;
    logic                r_box_valid;
    t_coord              r_lo [NUM_AXES];
    t_coord              r_hi [NUM_AXES];

    t_ctl                r_ctl [STG_FIN+1];
    t_coord              r_v [NUM_AXES];
    logic signed [PROD_W-1:0] r_prod [NUM_ROWS][NUM_AXES];
    logic signed [SUM_W-1:0]  r_psum [NUM_ROWS][2];
    logic signed [SUM_W-1:0]  r_t [NUM_ROWS];
    logic [SUM_W-1:0]    r_un [NUM_AXES];
    logic [SUM_W-1:0]    r_ud_abs;
    logic                r_dz;
    logic                r_nz [NUM_AXES];
    logic                r_nneg [NUM_AXES];
    logic                r_neg [NUM_AXES];
    t_lane               r_lane [STG_DIV0:STG_FIN-1][NUM_AXES];
    logic [SUM_W-1:0]    r_ud [STG_DIV0:STG_FIN-1];
    t_coord              n_p [NUM_AXES];
    logic                n_sat_fin;
    t_coord              r_p [NUM_AXES];
    logic                r_sat;

    t_coord              r_acc_min [NUM_AXES];
    t_coord              r_acc_max [NUM_AXES];
    logic                r_acc_sat;
    t_coord              n_min [NUM_AXES];
    t_coord              n_max [NUM_AXES];
    logic                n_sat;

    logic                r_out_valid;
    logic                r_out_box;
    t_coord              r_out_min [NUM_AXES];
    t_coord              r_out_max [NUM_AXES];
    logic                r_out_flag;

    // The pipeline advances unless a finished result is waiting.
    assign adv         = !r_out_valid || i_out_ready;
    assign o_in_ready  = adv && (!r_busy || r_k == LAST_CORNER);
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    // Matrix registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_PAIRS; i++) begin
                r_pair[i] <= '0;
            end
        end else if (i_cfg_valid && o_cfg_ready
                     && i_cfg_index < CFG_IDX_W'(NUM_PAIRS)) begin
            r_pair[i_cfg_index[PAIR_IDX_W-1:0]] <= i_cfg_data;
        end
    end

    // Unpack the matrix entries: pair 2r+c/2 holds row r, columns c and c+1.
    always_comb begin
        for (int r = 0; r < NUM_ROWS; r++) begin
            for (int c = 0; c < NUM_COLS; c++) begin
                if ((c % 2) == 1) begin
                    m[r][c] = t_coord'(r_pair[r*2 + c/2][PAIR_W-1:COORD_W]);
                end else begin
                    m[r][c] = t_coord'(r_pair[r*2 + c/2][COORD_W-1:0]);
                end
            end
        end
    end

    // Corner sequencer: a valid box issues corners 0..7, an invalid one a
    // single token.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_k    <= '0;
        end else if (adv) begin
            if (in_acc) begin
                r_busy <= 1'b1;
                r_k    <= i_box_valid_in ? 3'd0 : LAST_CORNER;
            end else if (r_busy) begin
                if (r_k == LAST_CORNER) begin
                    r_busy <= 1'b0;
                end else begin
                    r_k <= r_k + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_box_valid <= i_box_valid_in;
            r_lo[0]     <= i_in_min_x;
            r_lo[1]     <= i_in_min_y;
            r_lo[2]     <= i_in_min_z;
            r_hi[0]     <= i_in_max_x;
            r_hi[1]     <= i_in_max_y;
            r_hi[2]     <= i_in_max_z;
        end
    end

    // Control pipeline: valid bits travel alongside the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= STG_FIN; s++) begin
                r_ctl[s] <= '0;
            end
        end else if (adv) begin
            r_ctl[0].valid <= r_busy;
            r_ctl[0].first <= (r_k == 3'd0) || !r_box_valid;
            r_ctl[0].last  <= (r_k == LAST_CORNER);
            r_ctl[0].box   <= r_box_valid;
            for (int s = 1; s <= STG_FIN; s++) begin
                r_ctl[s] <= r_ctl[s-1];
            end
        end
    end

    // Datapath stages.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            // Corner select.
            for (int a = 0; a < NUM_AXES; a++) begin
                r_v[a] <= r_k[a] ? r_hi[a] : r_lo[a];
            end
            // Products of matrix entries and coordinates.
            for (int r = 0; r < NUM_ROWS; r++) begin
                for (int c = 0; c < NUM_AXES; c++) begin
                    r_prod[r][c] <= PROD_W'(m[r][c]) * PROD_W'(r_v[c]);
                end
            end
            // First level of the row sums; the w column multiplies 1.0.
            for (int r = 0; r < NUM_ROWS; r++) begin
                r_psum[r][0] <= SUM_W'(r_prod[r][0]) + SUM_W'(r_prod[r][1]);
                r_psum[r][1] <= SUM_W'(r_prod[r][2])
                                + (SUM_W'(m[r][NUM_COLS-1]) <<< FRAC_BITS);
            end
            // Row totals, floored back to the fixed-point format.
            for (int r = 0; r < NUM_ROWS; r++) begin
                r_t[r] <= (r_psum[r][0] + r_psum[r][1]) >>> FRAC_BITS;
            end
            // Magnitudes and signs for the divide by w.
            for (int a = 0; a < NUM_AXES; a++) begin
                r_un[a]   <= r_t[a][SUM_W-1] ? SUM_W'(-r_t[a]) : SUM_W'(r_t[a]);
                r_nz[a]   <= (r_t[a] == '0);
                r_nneg[a] <= r_t[a][SUM_W-1];
                r_neg[a]  <= r_t[a][SUM_W-1] ^ r_t[NUM_ROWS-1][SUM_W-1];
            end
            r_ud_abs <= r_t[NUM_ROWS-1][SUM_W-1] ? SUM_W'(-r_t[NUM_ROWS-1])
                                                 : SUM_W'(r_t[NUM_ROWS-1]);
            r_dz     <= (r_t[NUM_ROWS-1] == '0);
            // Divider setup: a quotient of 2^33 or more is caught here.
            for (int a = 0; a < NUM_AXES; a++) begin
                r_lane[STG_DIV0][a].rem  <= r_un[a] >> (QUO_W - FRAC_BITS);
                r_lane[STG_DIV0][a].lq   <= QUO_W'(r_un[a] << FRAC_BITS);
                r_lane[STG_DIV0][a].neg  <= r_neg[a];
                r_lane[STG_DIV0][a].dz   <= r_dz;
                r_lane[STG_DIV0][a].nz   <= r_nz[a];
                r_lane[STG_DIV0][a].nneg <= r_nneg[a];
                r_lane[STG_DIV0][a].ovf  <= ((r_un[a] >> (QUO_W - FRAC_BITS)) >= r_ud_abs);
            end
            r_ud[STG_DIV0] <= r_ud_abs;
            // One quotient bit per stage.
            for (int s = STG_DIV0 + 1; s < STG_FIN; s++) begin
                for (int a = 0; a < NUM_AXES; a++) begin
                    r_lane[s][a] <= div_step(r_lane[s-1][a], r_ud[s-1]);
                end
                r_ud[s] <= r_ud[s-1];
            end
            // Signed, saturated coordinates.
            for (int a = 0; a < NUM_AXES; a++) begin
                r_p[a] <= n_p[a];
            end
            r_sat <= n_sat_fin;
        end
    end

    // Saturation and sign of each projected coordinate.
    always_comb begin
        n_sat_fin = 1'b0;
        for (int a = 0; a < NUM_AXES; a++) begin
            priority if (r_lane[STG_FIN-1][a].dz) begin
                n_sat_fin = 1'b1;
                if (r_lane[STG_FIN-1][a].nz) begin
                    n_p[a] = '0;
                end else begin
                    n_p[a] = r_lane[STG_FIN-1][a].nneg ? SAT_NEG : SAT_POS;
                end
            end else if (r_lane[STG_FIN-1][a].ovf
                         || r_lane[STG_FIN-1][a].lq >
                            (r_lane[STG_FIN-1][a].neg ? LIM_NEG : LIM_POS)) begin
                n_sat_fin = 1'b1;
                n_p[a]    = r_lane[STG_FIN-1][a].neg ? SAT_NEG : SAT_POS;
            end else if (r_lane[STG_FIN-1][a].neg) begin
                n_p[a] = t_coord'(-r_lane[STG_FIN-1][a].lq[COORD_W-1:0]);
            end else begin
                n_p[a] = t_coord'(r_lane[STG_FIN-1][a].lq[COORD_W-1:0]);
            end
        end
    end

    // Running bounds over the corners of one box.
    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            if (r_ctl[STG_FIN].first || r_p[a] < r_acc_min[a]) begin
                n_min[a] = r_p[a];
            end else begin
                n_min[a] = r_acc_min[a];
            end
            if (r_ctl[STG_FIN].first || r_p[a] > r_acc_max[a]) begin
                n_max[a] = r_p[a];
            end else begin
                n_max[a] = r_acc_max[a];
            end
        end
        n_sat = (r_ctl[STG_FIN].first ? 1'b0 : r_acc_sat) | r_sat;
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_ctl[STG_FIN].valid) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                r_acc_min[a] <= n_min[a];
                r_acc_max[a] <= n_max[a];
            end
            r_acc_sat <= n_sat;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_ctl[STG_FIN].valid && r_ctl[STG_FIN].last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_ctl[STG_FIN].valid && r_ctl[STG_FIN].last) begin
            r_out_box <= r_ctl[STG_FIN].box;
            for (int a = 0; a < NUM_AXES; a++) begin
                r_out_min[a] <= r_ctl[STG_FIN].box ? n_min[a] : '0;
                r_out_max[a] <= r_ctl[STG_FIN].box ? n_max[a] : '0;
            end
            r_out_flag <= r_ctl[STG_FIN].box && n_sat;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_box_valid_out   = r_out_box;
    assign o_out_min_x       = r_out_min[0];
    assign o_out_min_y       = r_out_min[1];
    assign o_out_min_z       = r_out_min[2];
    assign o_out_max_x       = r_out_max[0];
    assign o_out_max_y       = r_out_max[1];
    assign o_out_max_z       = r_out_max[2];
    assign o_degenerate_flag = r_out_flag;

endmodule

@@ sv/atp_checker.sv @@
module atp_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic                          i_box_valid_in,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic                          o_box_valid_out,
    input atp_pkg::t_coord               o_out_min_x,
    input atp_pkg::t_coord               o_out_min_y,
    input atp_pkg::t_coord               o_out_min_z,
    input atp_pkg::t_coord               o_out_max_x,
    input atp_pkg::t_coord               o_out_max_y,
    input atp_pkg::t_coord               o_out_max_z,
    input logic                          o_degenerate_flag
);
    import atp_pkg::*;

    // A waiting result keeps its beat.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output beat dropped while stalled");

    // A waiting result keeps its x bounds and its flag.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            $stable(o_out_min_x) && $stable(o_out_max_x) && $stable(o_degenerate_flag))
        else $error("output payload changed while stalled");

    // A stalled output freezes the pipeline, so no box is taken.
    a_no_accept_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("input taken while output stalled");

    // A valid box occupies the corner sequencer while its corners issue.
    a_box_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_box_valid_in |=> !o_in_ready)
        else $error("next box taken before corners were issued");

    // An invalid box comes back zeroed.
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_box_valid_out |->
            o_out_min_x == '0 && o_out_min_y == '0 && o_out_min_z == '0
            && o_out_max_x == '0 && o_out_max_y == '0 && o_out_max_z == '0
            && !o_degenerate_flag)
        else $error("invalid box result not zeroed");

endmodule

bind aabb_transform_project_unit atp_checker u_atp_checker (.*);
